[rtl/erpm_pkg.sv]
// ----------------------------------------------------------------------------
// erpm_pkg
// Shared types and constants for the engine speed supervisor.
// ----------------------------------------------------------------------------
package erpm_pkg;

  // Item commands carried on the input tuser
  typedef enum logic [2:0] {
    CMD_EDGE       = 3'd0,
    CMD_TICK       = 3'd1,
    CMD_COMPRESS   = 3'd2,
    CMD_DECOMPRESS = 3'd3,
    CMD_SELF_START = 3'd4,
    CMD_SELF_STOP  = 3'd5
  } erpm_cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_COMP_RPM    = 3'd0,
    CFG_HIGH_RPM    = 3'd1,
    CFG_DECOMP_RPM  = 3'd2,
    CFG_FORCE_EN    = 3'd3,
    CFG_SELF_BLANK  = 3'd4,
    CFG_NO_RPM_TMO  = 3'd5
  } erpm_cfg_idx_e;

  localparam int unsigned RpmW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutW    = 24;

  localparam logic [RpmW-1:0]   RpmNumer        = 16'd60000;
  localparam logic [RpmW:0]     ForceMargin     = 17'd20;
  localparam logic [CountW-1:0] HoldCount       = 8'd250;
  localparam logic [CfgW-1:0]   SelfBlankReset  = 16'd1500;
  localparam logic [CfgW-1:0]   NoRpmTmoReset   = 16'd3000;

  // Configuration register file contents
  typedef struct packed {
    logic [RpmW-1:0] comp_rpm;
    logic [RpmW-1:0] high_rpm;
    logic [RpmW-1:0] decomp_rpm;
    logic            force_en;
    logic [CfgW-1:0] self_blank_ms;
    logic [CfgW-1:0] no_rpm_tmo_ms;
  } erpm_cfg_t;

  // Supervisor state flags
  typedef struct packed {
    logic self_on;
    logic did_comp;
    logic mach_on;
    logic high_fired;
    logic force_rep;
    logic decomp_rep;
    logic comp_rep;
  } erpm_flags_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } erpm_div_status_t;

endpackage

[rtl/erpm_cfg.sv]
// ----------------------------------------------------------------------------
// erpm_cfg
// Configuration register file: decodes index writes into the threshold set.
// ----------------------------------------------------------------------------
module erpm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [erpm_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [erpm_pkg::CfgW-1:0]   cfg_data_i,
  output erpm_pkg::erpm_cfg_t         cfg_o
);
  import erpm_pkg::*;

  erpm_cfg_t cfg_q;

  // always able to take a write
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comp_rpm      <= '0;
      cfg_q.high_rpm      <= '0;
      cfg_q.decomp_rpm    <= '0;
      cfg_q.force_en      <= 1'b0;
      cfg_q.self_blank_ms <= SelfBlankReset;
      cfg_q.no_rpm_tmo_ms <= NoRpmTmoReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_COMP_RPM:   cfg_q.comp_rpm      <= cfg_data_i;
        CFG_HIGH_RPM:   cfg_q.high_rpm      <= cfg_data_i;
        CFG_DECOMP_RPM: cfg_q.decomp_rpm    <= cfg_data_i;
        CFG_FORCE_EN:   cfg_q.force_en      <= cfg_data_i[0];
        CFG_SELF_BLANK: cfg_q.self_blank_ms <= cfg_data_i;
        CFG_NO_RPM_TMO: cfg_q.no_rpm_tmo_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[rtl/erpm_div.sv]
// ----------------------------------------------------------------------------
// erpm_div
// Bit-serial restoring divider: 60000 / period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erpm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [erpm_pkg::RpmW-1:0]     divisor_i,
  output logic [erpm_pkg::RpmW-1:0]     quotient_o,
  output erpm_pkg::erpm_div_status_t    status_o
);
  import erpm_pkg::*;

  logic [RpmW:0]   rem_q, rem_d;
  logic [RpmW-1:0] quo_q, quo_d;
  logic [RpmW-1:0] div_q;
  logic [3:0]      cnt_q;
  logic            busy_q, done_q;
  logic [RpmW:0]   rem_sh;
  logic [RpmW+1:0] trial;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem_q[RpmW-1:0], quo_q[RpmW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, div_q};
    if (!trial[RpmW+1]) begin
      rem_d = trial[RpmW:0];
      quo_d = {quo_q[RpmW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      quo_d = {quo_q[RpmW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'hF) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= RpmNumer;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

[rtl/engine_rpm_event_supervisor.sv]
// ----------------------------------------------------------------------------
// engine_rpm_event_supervisor
// Engine speed supervisor: tacho edges, ticks and machine commands in,
// one event set with speed and machine status out per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser holds the command, tdata the period and time.
//   Every accepted item yields exactly one result on the output stream.
//   Thresholds are written through the cfg channel, index = register number,
//   while no item is in flight; cfg_ready_o is always high.
// Item flow:
//   An edge item with non-zero period runs the bit-serial divider; the
//   sequencer then picks up the quotient and performs the update, which
//   registers the result. Any other item goes straight to the update.
//   A further item is taken only once the update is done; one item is in
//   work at a time.
// Reset:
//   Speed, times, counters and flags clear; blanking is 1500 ms and the
//   no-speed timeout 3000 ms, other thresholds zero.
// Stall:
//   The result sits in an output register; the next item is taken and
//   worked on, and its update waits until the pending result is transferred.
// ----------------------------------------------------------------------------
module engine_rpm_event_supervisor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [erpm_pkg::InDataW-1:0]   s_axis_tdata,  // period_ms[15:0], now_ms[47:16]
  input  logic [2:0]                     s_axis_tuser,  // command[2:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [erpm_pkg::OutW-1:0]      m_axis_tdata,  // ev_force_start[0], ev_start_rpm[1],
                                                        // ev_decomp_rpm[2], ev_high_rpm[3],
                                                        // ev_comp_rpm[4], ev_no_rpm[5],
                                                        // rpm_now[21:6], machine_running[22],
                                                        // zero[23]
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [erpm_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [erpm_pkg::CfgW-1:0]      cfg_data_i
);
  import erpm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_e;

  state_e            state_q;
  erpm_cfg_t         cfg;
  erpm_div_status_t  div_st;
  logic [RpmW-1:0]   quotient;
  logic              div_start;

  // latched item
  logic [2:0]        cmd_q;
  logic [RpmW-1:0]   period_q;
  logic [TimeW-1:0]  now_q;

  // supervisor state
  logic [RpmW-1:0]   rpm_q, rpm_d;
  logic [TimeW-1:0]  last_edge_q, last_edge_d;
  logic [TimeW-1:0]  self_start_q, self_start_d;
  logic [CountW-1:0] start_cnt_q, start_cnt_d;
  logic [CountW-1:0] high_cnt_q, high_cnt_d;
  erpm_flags_t       flags_q, flags_d;
  logic [5:0]        ev_d;

  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q;
  logic              commit;

  logic [TimeW-1:0]  since_self, since_edge;
  logic              blanked;
  logic [RpmW:0]     force_level;
  logic [RpmW-1:0]   r;

  erpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign div_start     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_EDGE)
                         && (s_axis_tdata[RpmW-1:0] != '0);

  erpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (s_axis_tdata[RpmW-1:0]),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  assign commit = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  // elapsed times and thresholds
  assign r           = quotient;
  assign since_self  = now_q - self_start_q;
  assign since_edge  = now_q - last_edge_q;
  assign blanked     = flags_q.self_on && (since_self < {16'd0, cfg.self_blank_ms});
  assign force_level = {1'b0, cfg.comp_rpm} + ForceMargin;

  // per-item state update
  always_comb begin
    rpm_d        = rpm_q;
    last_edge_d  = last_edge_q;
    self_start_d = self_start_q;
    start_cnt_d  = start_cnt_q;
    high_cnt_d   = high_cnt_q;
    flags_d      = flags_q;
    ev_d         = '0;
    case (cmd_q)
      CMD_EDGE: begin
        last_edge_d = now_q;
        if (period_q != '0) begin
          rpm_d = r;
          if (!blanked) begin
            // start qualifier and force start
            if (flags_q.did_comp) begin
              if (!flags_q.force_rep && cfg.force_en && ({1'b0, r} > force_level)) begin
                flags_d.force_rep = 1'b1;
                ev_d[0]           = 1'b1;
              end
              if ((r > cfg.comp_rpm) && (start_cnt_q < HoldCount)) begin
                start_cnt_d = start_cnt_q + 8'd1;
              end else if (start_cnt_q >= HoldCount) begin
                flags_d.did_comp = 1'b0;
                ev_d[1]          = 1'b1;
              end
            end
            // over-speed release
            if (flags_q.high_fired && (r < cfg.high_rpm)) begin
              high_cnt_d         = '0;
              flags_d.high_fired = 1'b0;
            end
            if (flags_q.mach_on) begin
              if ((r <= cfg.decomp_rpm) && !flags_q.decomp_rep) begin
                flags_d.decomp_rep = 1'b1;
                ev_d[2]            = 1'b1;
              end
              // debounced over-speed alarm
              if (!flags_d.high_fired) begin
                if (r > cfg.high_rpm) begin
                  if (high_cnt_d < HoldCount) begin
                    high_cnt_d = high_cnt_d + 8'd1;
                  end else begin
                    flags_d.high_fired = 1'b1;
                    ev_d[3]            = 1'b1;
                    high_cnt_d         = '0;
                  end
                end else begin
                  high_cnt_d = '0;
                end
              end
            end else if (!flags_q.comp_rep && (r >= cfg.comp_rpm)) begin
              flags_d.comp_rep = 1'b1;
              ev_d[4]          = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if ((rpm_q != '0) && (since_edge >= {16'd0, cfg.no_rpm_tmo_ms})) begin
          rpm_d       = '0;
          ev_d[5]     = 1'b1;
          start_cnt_d = '0;
          flags_d     = '0;
          flags_d.self_on = flags_q.self_on;
        end
      end
      CMD_COMPRESS: begin
        flags_d.did_comp = 1'b1;
        flags_d.mach_on  = 1'b1;
        flags_d.comp_rep = 1'b0;
        start_cnt_d      = '0;
      end
      CMD_DECOMPRESS: begin
        start_cnt_d     = '0;
        flags_d         = '0;
        flags_d.self_on = flags_q.self_on;
      end
      CMD_SELF_START: begin
        flags_d.self_on = 1'b1;
        self_start_d    = now_q;
      end
      CMD_SELF_STOP: flags_d.self_on = 1'b0;
      default: ;
    endcase
  end

  // sequencer, supervisor state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rpm_q        <= '0;
      last_edge_q  <= '0;
      self_start_q <= '0;
      start_cnt_q  <= '0;
      high_cnt_q   <= '0;
      flags_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= div_start ? ST_DIV : ST_EXEC;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q      <= ST_IDLE;
            rpm_q        <= rpm_d;
            last_edge_q  <= last_edge_d;
            self_start_q <= self_start_d;
            start_cnt_q  <= start_cnt_d;
            high_cnt_q   <= high_cnt_d;
            flags_q      <= flags_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q    <= s_axis_tuser;
      period_q <= s_axis_tdata[RpmW-1:0];
      now_q    <= s_axis_tdata[InDataW-1:RpmW];
    end
    if (commit) begin
      out_data_q <= {1'b0, flags_d.mach_on, rpm_d, ev_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/erpm_chk.sv]
// ----------------------------------------------------------------------------
// erpm_chk
// Port-level checker for the engine speed supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module erpm_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [erpm_pkg::OutW-1:0]    m_axis_tdata
);
  import erpm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // speed loss clears speed and turns the machine off
  a_no_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> (m_axis_tdata[21:6] == '0) && !m_axis_tdata[22])
    else $error("no-speed event with speed or machine on");

  // compress crossing only while off, decompress crossing only while on
  a_cross_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[22])
                      && !(m_axis_tdata[2] && !m_axis_tdata[22]))
    else $error("speed crossing event in wrong machine state");

endmodule

bind engine_rpm_event_supervisor erpm_chk u_erpm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
